/* rtl/core/fbfl_pkg.sv */
// Shared types and constants for the fixed block free list allocator.
package fbfl_pkg;

  localparam int unsigned WordBytes  = 8;
  localparam int unsigned IndexSpace = 1024;
  localparam int unsigned IdxW       = 10;
  localparam int unsigned CountW     = 11;
  localparam int unsigned PoolW      = 24;
  localparam int unsigned BlkW       = 13;
  localparam int unsigned SizeW      = 14;
  localparam int unsigned OffW       = 23;
  localparam int unsigned CountMax   = 2047;

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_FREE    = 2'd1,
    ACT_REBUILD = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]      action;
    logic [IdxW-1:0] block_index;
  } in_req_t;

  typedef struct packed {
    status_e           status;
    logic [IdxW-1:0]   granted_index;
    logic [OffW-1:0]   byte_offset;
    logic [CountW-1:0] free_count;
  } out_rsp_t;

endpackage

/* rtl/core/fbfl_div.sv */
// Restoring divider, one quotient bit per cycle, for the block count.
module fbfl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [fbfl_pkg::PoolW-1:0] dividend_i,
  input  logic [fbfl_pkg::SizeW-1:0] divisor_i,
  output logic                       done_o,
  output logic [fbfl_pkg::PoolW-1:0] quotient_o
);
  import fbfl_pkg::*;

  localparam int unsigned CntW = $clog2(PoolW);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SizeW:0]  rem_q, rem_d;
  logic [PoolW-1:0] quo_q, quo_d;
  logic [SizeW-1:0] dsr_q, dsr_d;
  logic [SizeW:0]  rem_sh;
  logic            fits;

  assign rem_sh = {rem_q[SizeW-1:0], quo_q[PoolW-1]};
  assign fits   = rem_sh >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (rem_sh - {1'b0, dsr_q}) : rem_sh;
      quo_d = {quo_q[PoolW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(PoolW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

/* rtl/core/fixed_block_free_list_allocator_top.sv */
// Top level of the fixed block free list allocator.
//
// Manages a pool of equal-size blocks through a singly linked free list of
// block indices held in an on-chip link memory (one entry per block,
// registered read). Each request allocates (pops the list head), frees
// (pushes an index back onto the head) or rebuilds the list from the
// pool_bytes / block_bytes registers. Every request returns one result with
// status, block index, byte offset (one header word plus index times the
// word-aligned block size) and the running free count. Requests are handled
// one at a time: allocate, free and the unused action code go through
// capture, then one link memory read or write plus the offset multiply.
// Rebuild runs a bit-serial divider for the block count, then writes the
// link memory one entry per cycle. The link memory has no reset; the list is
// empty until the first rebuild. A free of an index at or above the built
// count returns status out-of-range and changes nothing. A double free is
// pushed again and the count saturates at 2047. Configuration writes take
// effect at the next rebuild; the user must make them only while no request
// is in flight, as the block itself does not enforce it.
module fixed_block_free_list_allocator_top #(
  parameter int unsigned MAX_BLOCKS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fbfl_pkg::in_req_t   in_req_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fbfl_pkg::out_rsp_t  out_rsp_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import fbfl_pkg::*;

  // Number of blocks that can ever be built, and the link memory depth.
  localparam int unsigned Cap = (MAX_BLOCKS > IndexSpace) ? IndexSpace : MAX_BLOCKS;
  localparam int unsigned AW  = $clog2(Cap);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,  // waiting for a request
    S_EXEC = 5'b00010,  // link read data ready, finish alloc / free or start a rebuild
    S_DIV  = 5'b00100,  // block count divide in progress
    S_LINK = 5'b01000,  // writing ascending links
    S_FIN  = 5'b10000   // publish rebuild result
  } state_e;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [PoolW-1:0] pool_q;
  logic [BlkW-1:0]  blk_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= PoolW'(8200);
      blk_q  <= BlkW'(8);
    end else if (cfg_wr) begin
      if (paddr[2]) blk_q <= pwdata[BlkW-1:0];
      else          pool_q <= pwdata[PoolW-1:0];
    end
  end

  assign prdata = paddr[2] ? {{(32-BlkW){1'b0}}, blk_q} : {{(32-PoolW){1'b0}}, pool_q};

  // ---------------------------------------------------------------------
  // Control and list state
  // ---------------------------------------------------------------------
  state_e            state_q, state_d;
  in_req_t           req_q, req_d;
  logic [IdxW-1:0]   head_q, head_d;
  logic              head_valid_q, head_valid_d;
  logic [CountW-1:0] free_q, free_d;
  logic [CountW-1:0] built_q, built_d;
  logic [SizeW-1:0]  aligned_q, aligned_d;
  logic [CountW-1:0] n_q, n_d;        // block count of the rebuild in progress
  logic [CountW-1:0] cnt_q, cnt_d;    // link sweep position
  logic              out_valid_q, out_valid_d;
  out_rsp_t          out_rsp_q, out_rsp_d;

  // Link memory ports
  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr;
  logic [IdxW-1:0] mem_wdata;
  logic [IdxW-1:0] rdata_q;
  logic [IdxW-1:0] link_mem [Cap];

  always_ff @(posedge clk_i) begin
    if (mem_we) link_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= link_mem[head_q[AW-1:0]];
  end

  // Block size aligned up to whole words, at least one word.
  logic [SizeW-1:0] blk_round, blk_aligned;
  logic [PoolW-1:0] dividend;
  assign blk_round   = {1'b0, blk_q} + SizeW'(WordBytes - 1);
  assign blk_aligned = (blk_q < BlkW'(WordBytes)) ? SizeW'(WordBytes)
                                                   : (blk_round & ~SizeW'(WordBytes - 1));
  assign dividend    = (pool_q > PoolW'(WordBytes)) ? (pool_q - PoolW'(WordBytes)) : '0;

  // Divider for the block count
  logic             div_start, div_done;
  logic [PoolW-1:0] div_quo;
  logic [CountW-1:0] div_cnt;

  fbfl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (blk_aligned),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign div_cnt = (div_quo > PoolW'(Cap)) ? CountW'(Cap) : div_quo[CountW-1:0];

  // Byte offset of the granted block
  logic [IdxW-1:0]  grant;
  logic [PoolW-1:0] prod;
  logic [OffW-1:0]  offset;
  assign grant  = (req_q.action == ACT_ALLOC) ? head_q : req_q.block_index;
  assign prod   = {{(PoolW-IdxW){1'b0}}, grant} * {{(PoolW-SizeW){1'b0}}, aligned_q};
  assign offset = OffW'(PoolW'(WordBytes) + prod);

  logic             out_free;
  logic [CountW:0]  cnt_inc;
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_inc  = {1'b0, cnt_q} + 1'b1;

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    head_d       = head_q;
    head_valid_d = head_valid_q;
    free_d       = free_q;
    built_d      = built_q;
    aligned_d    = aligned_q;
    n_d          = n_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_rsp_d    = out_rsp_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = cnt_q[AW-1:0];
    mem_wdata    = '0;
    div_start    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i;
          mem_re  = 1'b1;   // head link fetched for a possible allocate
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (req_q.action == ACT_REBUILD) begin
          aligned_d = blk_aligned;
          div_start = 1'b1;
          state_d   = S_DIV;
        end else if (out_free) begin
          out_valid_d            = 1'b1;
          out_rsp_d.status       = STAT_DONE;
          out_rsp_d.granted_index = '0;
          out_rsp_d.byte_offset  = '0;
          state_d                = S_IDLE;
          case (req_q.action)
            ACT_ALLOC: begin
              if (!head_valid_q) begin
                out_rsp_d.status = STAT_EMPTY;
              end else begin
                head_d = rdata_q;
                if (free_q != '0) free_d = free_q - 1'b1;
                head_valid_d = (free_d != '0);
                out_rsp_d.granted_index = grant;
                out_rsp_d.byte_offset   = offset;
              end
            end
            ACT_FREE: begin
              if ({1'b0, req_q.block_index} >= built_q) begin
                out_rsp_d.status = STAT_RANGE;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = req_q.block_index[AW-1:0];
                mem_wdata = head_q;
                head_d    = req_q.block_index;
                if (free_q != CountW'(CountMax)) free_d = free_q + 1'b1;
                head_valid_d = 1'b1;
                out_rsp_d.granted_index = grant;
                out_rsp_d.byte_offset   = offset;
              end
            end
            default: begin
            end
          endcase
          out_rsp_d.free_count = free_d;
        end
      end

      S_DIV: begin
        if (div_done) begin
          n_d     = div_cnt;
          cnt_d   = '0;
          state_d = (div_cnt == '0) ? S_FIN : S_LINK;
        end
      end

      S_LINK: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q[AW-1:0];
        // last block terminates the list with index zero
        mem_wdata = (cnt_inc[CountW-1:0] == n_q) ? '0 : cnt_inc[IdxW-1:0];
        cnt_d     = cnt_inc[CountW-1:0];
        if (cnt_inc[CountW-1:0] == n_q) state_d = S_FIN;
      end

      S_FIN: begin
        if (out_free) begin
          built_d      = n_q;
          free_d       = n_q;
          head_d       = '0;
          head_valid_d = (n_q != '0);
          out_valid_d  = 1'b1;
          out_rsp_d.status        = STAT_DONE;
          out_rsp_d.granted_index = '0;
          out_rsp_d.byte_offset   = '0;
          out_rsp_d.free_count    = n_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      head_q       <= '0;
      head_valid_q <= 1'b0;
      free_q       <= '0;
      built_q      <= '0;
      aligned_q    <= SizeW'(WordBytes);
      n_q          <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      free_q       <= free_d;
      built_q      <= built_d;
      aligned_q    <= aligned_d;
      n_q          <= n_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    out_rsp_q <= out_rsp_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // head flag tracks the running count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_q == (free_q != '0))
    else $error("head valid flag out of step with free count");

  // never more blocks built than the link memory holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    built_q <= CountW'(Cap))
    else $error("built block count exceeds capacity");

  // a rejected request reports no block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.status == STAT_RANGE || out_rsp_o.status == STAT_EMPTY)
    |-> out_rsp_o.granted_index == '0 && out_rsp_o.byte_offset == '0)
    else $error("rejected request reports a block");

  // a free that writes the link memory stays inside the built range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && state_q == S_EXEC |-> {1'b0, req_q.block_index} < built_q)
    else $error("link write outside built range");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the fixed block free list allocator.
`timescale 1ns / 1ps

module tb;
  import fbfl_pkg::*;

  localparam int unsigned MaxBlocks  = 1024;
  localparam logic [1:0]  ActUnused  = 2'd3;
  localparam logic [2:0]  RegPool    = 3'd0;
  localparam logic [2:0]  RegBlock   = 3'd4;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned PhaseItems = 48;
  localparam int unsigned FillItems  = 1030;
  localparam int unsigned NumRows    = 16;

  typedef enum int unsigned {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  // One row of the directed table; rsp only counts when known is set.
  typedef struct {
    logic [1:0]      act;
    logic [IdxW-1:0] idx;
    bit              known;
    out_rsp_t        rsp;
  } req_row_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_req   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_rsp_t    out_rsp;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  fixed_block_free_list_allocator_top #(
    .MAX_BLOCKS(MaxBlocks)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Local copy of the pool: link words, list head, counts and settings.
  logic [IdxW-1:0] link_mem [IndexSpace];
  logic [IdxW-1:0] head_idx;
  bit              head_ok;
  int unsigned     free_cnt;
  int unsigned     built_cnt;
  int unsigned     blk_size;
  int unsigned     cfg_pool;
  int unsigned     cfg_block;

  out_rsp_t    due_results [$];
  int unsigned send_pct  = 0;
  int unsigned recv_pct  = 0;
  int unsigned miss_cnt  = 0;
  int unsigned sent_cnt  = 0;
  int unsigned seen_cnt  = 0;
  int unsigned empty_cnt = 0;
  int unsigned range_cnt = 0;

  // Pool settings per random phase: extremes, tiny pools, sub-word and
  // oversized blocks, and pools too small for a single block.
  int unsigned pool_cfg  [NumPhases] = '{8200, 200, 16777215, 72, 9000, 8, 100, 16, 0};
  int unsigned block_cfg [NumPhases] = '{8, 24, 8191, 1, 4096, 0, 13, 5, 4096};

  req_row_t dir_rows [NumRows];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Rebuild: word-align the block size, derive the count, link ascending.
  function automatic void relink_pool();
    int unsigned n = 0;
    blk_size = (cfg_block < WordBytes) ? WordBytes
             : ((cfg_block + WordBytes - 1) / WordBytes) * WordBytes;
    if (cfg_pool > WordBytes) n = (cfg_pool - WordBytes) / blk_size;
    if (n > MaxBlocks) n = MaxBlocks;
    if (n > IndexSpace) n = IndexSpace;
    for (int unsigned i = 0; i < n; i++)
      link_mem[i] = (i + 1 == n) ? '0 : IdxW'(i + 1);
    built_cnt = n;
    free_cnt  = n;
    head_idx  = '0;
    head_ok   = (n != 0);
  endfunction

  // Result of one request against the local pool; updates the pool.
  function automatic out_rsp_t pool_step(in_req_t r);
    out_rsp_t        res;
    logic [IdxW-1:0] g;
    bit              hit;
    res = '0;
    g   = '0;
    hit = 1'b0;
    case (r.action)
      ACT_ALLOC: begin
        if (!head_ok) begin
          res.status = STAT_EMPTY;
        end else begin
          g        = head_idx;
          head_idx = link_mem[g];
          if (free_cnt > 0) free_cnt--;
          head_ok  = (free_cnt != 0);
          hit      = 1'b1;
        end
      end
      ACT_FREE: begin
        if (r.block_index >= built_cnt) begin
          res.status = STAT_RANGE;
        end else begin
          g                       = r.block_index;
          link_mem[r.block_index] = head_idx;
          head_idx                = r.block_index;
          // a double free is pushed again; the count saturates
          if (free_cnt < CountMax) free_cnt++;
          head_ok = 1'b1;
          hit     = 1'b1;
        end
      end
      ACT_REBUILD: relink_pool();
      default: ;
    endcase
    if (hit) begin
      res.granted_index = g;
      res.byte_offset   = OffW'(WordBytes + g * blk_size);
    end
    res.free_count = CountW'(free_cnt);
    return res;
  endfunction

  function automatic void set_mode(idle_e m);
    case (m)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 65; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 65; end
      default:   begin send_pct = 30; recv_pct = 30; end
    endcase
  endfunction

  task automatic report_miss(input string what, input longint want, input longint got);
    miss_cnt++;
    if (miss_cnt <= 10)
      $display("ERROR %s: expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  // Drives one request; returns at the rising edge that accepts it.
  task automatic issue(input logic [1:0] act, input logic [IdxW-1:0] idx,
                       input bit known, input out_rsp_t fixed);
    in_req_t  r;
    out_rsp_t want;
    r.action      = act;
    r.block_index = idx;
    @(negedge clk_i);
    while (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    want = pool_step(r);
    due_results.push_back(known ? fixed : want);
    sent_cnt++;
  endtask

  // Drops valid and waits until every owed result has come back.
  task automatic settle(input int unsigned extra);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // Register write followed by a read-back of the same register.
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] value);
    logic [31:0] keep;
    logic [31:0] seen;
    keep = (addr == RegPool) ? 32'h00FF_FFFF : 32'h0000_1FFF;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    seen = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == RegPool) cfg_pool = value & keep;
    else cfg_block = value & keep;
    if (seen !== (value & keep)) report_miss("register read-back", value & keep, seen);
  endtask

  // Result side stalls at random per phase.
  always @(negedge clk_i) begin
    out_stall <= (recv_pct != 0) && ($urandom_range(99) < recv_pct);
  end

  // Every accepted result is matched to the oldest owed one.
  always @(posedge clk_i) begin : result_check
    out_rsp_t want;
    if (rst_ni && out_valid && !out_stall) begin
      seen_cnt++;
      if (out_rsp.status == STAT_EMPTY) empty_cnt++;
      if (out_rsp.status == STAT_RANGE) range_cnt++;
      if (due_results.size() == 0) begin
        report_miss("result with none owed, free count", 0, out_rsp.free_count);
      end else begin
        want = due_results.pop_front();
        if (out_rsp.status !== want.status)
          report_miss("status", want.status, out_rsp.status);
        if (out_rsp.granted_index !== want.granted_index)
          report_miss("granted index", want.granted_index, out_rsp.granted_index);
        if (out_rsp.byte_offset !== want.byte_offset)
          report_miss("byte offset", want.byte_offset, out_rsp.byte_offset);
        if (out_rsp.free_count !== want.free_count)
          report_miss("free count", want.free_count, out_rsp.free_count);
      end
    end
  end

  initial begin
    int unsigned     roll;
    int unsigned     alloc_bias;
    logic [1:0]      act;
    logic [IdxW-1:0] idx;

    foreach (link_mem[i]) link_mem[i] = '0;
    head_idx  = '0;
    head_ok   = 1'b0;
    free_cnt  = 0;
    built_cnt = 0;
    blk_size  = WordBytes;
    cfg_pool  = 8200;
    cfg_block = 8;
    alloc_bias = 50;

    // Fresh pool is empty; rebuild on reset settings gives 1024 blocks.
    dir_rows = '{
      '{ACT_ALLOC,   10'd0,    1'b1, '{STAT_EMPTY, 10'd0,    23'd0,    11'd0}},
      '{ACT_FREE,    10'd0,    1'b1, '{STAT_RANGE, 10'd0,    23'd0,    11'd0}},
      '{ACT_FREE,    10'd1023, 1'b1, '{STAT_RANGE, 10'd0,    23'd0,    11'd0}},
      '{ActUnused,   10'd1023, 1'b1, '{STAT_DONE,  10'd0,    23'd0,    11'd0}},
      '{ACT_REBUILD, 10'd0,    1'b1, '{STAT_DONE,  10'd0,    23'd0,    11'd1024}},
      '{ACT_ALLOC,   10'd1023, 1'b1, '{STAT_DONE,  10'd0,    23'd8,    11'd1023}},
      '{ACT_ALLOC,   10'd0,    1'b1, '{STAT_DONE,  10'd1,    23'd16,   11'd1022}},
      '{ACT_FREE,    10'd1023, 1'b1, '{STAT_DONE,  10'd1023, 23'd8192, 11'd1023}},
      '{ACT_FREE,    10'd1023, 1'b0, '0},   // double free
      '{ACT_ALLOC,   10'd0,    1'b0, '0},
      '{ACT_ALLOC,   10'd0,    1'b0, '0},
      '{ACT_ALLOC,   10'd0,    1'b0, '0},
      '{ACT_FREE,    10'd0,    1'b0, '0},
      '{ActUnused,   10'd0,    1'b0, '0},
      '{ACT_REBUILD, 10'd1023, 1'b0, '0},
      '{ACT_ALLOC,   10'd0,    1'b0, '0}
    };

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    set_mode(IDLE_NONE);
    foreach (dir_rows[i])
      issue(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].known, dir_rows[i].rsp);

    // Push far past the built count so the free count hits its ceiling.
    issue(ACT_REBUILD, '0, 1'b0, '0);
    for (int k = 0; k < FillItems; k++)
      issue(ACT_FREE, IdxW'($urandom_range(built_cnt - 1)), 1'b0, '0);

    for (int p = 0; p < NumPhases; p++) begin
      settle(4);
      write_reg(RegPool, pool_cfg[p]);
      write_reg(RegBlock, block_cfg[p]);
      set_mode(idle_e'(p % 4));
      issue(ACT_REBUILD, IdxW'($urandom_range(1023)), 1'b0, '0);
      for (int k = 0; k < PhaseItems; k++) begin
        // switch at random between allocate-heavy and free-heavy stretches
        if (k % 32 == 0) alloc_bias = $urandom_range(1) ? 75 : 25;
        if ($urandom_range(99) == 0) settle(0);
        roll = $urandom_range(99);
        if (roll < 4) act = ACT_REBUILD;
        else if (roll < 7) act = ActUnused;
        else if ($urandom_range(99) < alloc_bias) act = ACT_ALLOC;
        else act = ACT_FREE;
        if (act == ACT_FREE && built_cnt != 0 && $urandom_range(99) < 80)
          idx = IdxW'($urandom_range(built_cnt - 1));
        else
          idx = IdxW'($urandom_range(1023));
        issue(act, idx, 1'b0, '0);
      end
    end

    settle(50);
    $display("Ran %0d requests over %0d pool settings and a count-ceiling fill run;",
             sent_cnt, NumPhases + 1);
    $display("checked %0d results, %0d with an empty pool and %0d out-of-range frees.",
             seen_cnt, empty_cnt, range_cnt);
    if (miss_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/fbfl_pkg.sv
rtl/core/fbfl_div.sv
rtl/core/fixed_block_free_list_allocator_top.sv
tb/tb.sv
